// ===== src/rds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_pkg: shared types and constants
// Widths, register addresses and the sorter cell word for the depth sorter.
// ----------------------------------------------------------------------------
package rds_pkg;
  localparam int MaxPolys = 32;
  localparam int MaxVerts = 16;
  localparam int CntW     = $clog2(MaxPolys + 1);
  localparam int VcW      = $clog2(MaxVerts + 1);
  localparam int SumW     = 24 + VcW;
  localparam int CoefW    = 18;
  localparam int CoordW   = 20;
  localparam int OutW     = 24;
  localparam int IdxW     = 5;

  localparam logic [2:0] RegRow0 = 3'd0;
  localparam logic [2:0] RegRow1 = 3'd1;
  localparam logic [2:0] RegRow2 = 3'd2;
  localparam logic [2:0] RegAxis = 3'd3;
  localparam logic [2:0] RegAvg  = 3'd4;

  localparam logic [1:0] AxisNone = 2'd3;

  typedef struct packed {
    logic signed [OutW-1:0] key;
    logic [IdxW-1:0]        idx;
  } cell_t;

  typedef struct packed {
    logic  ins;   // insert new word this cycle
    logic  clr;   // drop all entries
    logic  shift; // shift one entry toward the head
    cell_t word;
  } cell_ctl_t;
endpackage

// ===== src/rotate_and_depth_sort_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_and_depth_sort_core: vertex rotation and painter's depth sort
// Rotates vertices, keeps a per-polygon depth key in a row of sorter cells,
// and drains the back-to-front order at frame end (arrival order with no depth axis).
// ----------------------------------------------------------------------------
// Each vertex passes through the StMul and StEmit states before its word is
//   strobed; a polygon end that enters the order adds the StIns state,
//   preceded by the serial divider (StDiv) in average mode; a frame end then
//   drains one word per polygon in the order. A new vertex is taken only while idle.
// The receiver cannot stall; words are strobed for one cycle each.
// Reset clears control state; configuration returns to the identity matrix.
module rotate_and_depth_sort_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [rds_pkg::CoordW-1:0]   x_in_i,
  input  logic signed [rds_pkg::CoordW-1:0]   y_in_i,
  input  logic signed [rds_pkg::CoordW-1:0]   z_in_i,
  input  logic                                end_of_polygon_i,
  input  logic                                end_of_frame_i,
  output logic                                strobe_o,
  output logic                                kind_o,
  output logic signed [rds_pkg::OutW-1:0]     x_out_o,
  output logic signed [rds_pkg::OutW-1:0]     y_out_o,
  output logic signed [rds_pkg::OutW-1:0]     z_out_o,
  output logic [rds_pkg::IdxW-1:0]            polygon_index_o,
  output logic                                overflow_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [5:0]                          paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready
);
  import rds_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StEmit = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StIns  = 3'd4;
  localparam logic [2:0] StDrn  = 3'd5;

  logic [53:0] row0_q, row1_q, row2_q;
  logic [1:0]  axis_q;
  logic        avg_q;
  logic        wr;
  logic [2:0]  ra;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ra     = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= 54'd65536;
      row1_q <= 54'd65536 << 18;
      row2_q <= 54'd65536 << 36;
      axis_q <= 2'd2;
      avg_q  <= 1'b1;
    end else if (wr) begin
      case (ra)
        RegRow0: row0_q <= pwdata[53:0];
        RegRow1: row1_q <= pwdata[53:0];
        RegRow2: row2_q <= pwdata[53:0];
        RegAxis: axis_q <= pwdata[1:0];
        RegAvg:  avg_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ra)
      RegRow0: prdata = {10'd0, row0_q};
      RegRow1: prdata = {10'd0, row1_q};
      RegRow2: prdata = {10'd0, row2_q};
      RegAxis: prdata = {62'd0, axis_q};
      RegAvg:  prdata = {63'd0, avg_q};
      default: prdata = '0;
    endcase
  end

  // ---- vertex capture and rotation
  logic [2:0] st_q, st_d;
  logic signed [CoordW-1:0] xv_q, yv_q, zv_q;
  logic eop_q, eof_q;
  logic signed [OutW-1:0] r0, r1, r2, d;

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      xv_q <= x_in_i; yv_q <= y_in_i; zv_q <= z_in_i;
      eop_q <= end_of_polygon_i || end_of_frame_i;
      eof_q <= end_of_frame_i;
    end
  end

  rds_rotate u_rot0 (.clk_i, .row_i(row0_q), .x_i(xv_q), .y_i(yv_q), .z_i(zv_q), .r_o(r0));
  rds_rotate u_rot1 (.clk_i, .row_i(row1_q), .x_i(xv_q), .y_i(yv_q), .z_i(zv_q), .r_o(r1));
  rds_rotate u_rot2 (.clk_i, .row_i(row2_q), .x_i(xv_q), .y_i(yv_q), .z_i(zv_q), .r_o(r2));

  always_comb begin
    case (axis_q)
      2'd0:    d = r0;
      2'd1:    d = r1;
      2'd2:    d = r2;
      default: d = '0;
    endcase
  end

  // ---- per-polygon accumulation
  logic [CntW-1:0]        pcnt_q;
  logic signed [SumW-1:0] sum_q;
  logic [VcW-1:0]         vcnt_q;
  logic signed [OutW-1:0] first_q;
  logic                   ovf_q;
  logic                   dropped;
  logic signed [SumW-1:0] sum_n;
  logic [VcW-1:0]         vcnt_n;
  logic signed [OutW-1:0] first_n;
  logic signed [OutW-1:0] key_q;
  logic [CntW-1:0]        drn_q;
  logic [CntW-1:0]        didx_q;

  assign dropped = pcnt_q >= CntW'(MaxPolys);
  assign first_n = (vcnt_q == '0) ? d : first_q;
  assign sum_n   = (vcnt_q < VcW'(MaxVerts)) ? sum_q + SumW'(d) : sum_q;
  assign vcnt_n  = (vcnt_q < VcW'(MaxVerts)) ? vcnt_q + 1'b1 : vcnt_q;

  // the closing vertex is already part of the sum and count
  logic div_go, div_done;
  logic signed [OutW-1:0] div_q;
  rds_divider u_div (
    .clk_i, .rst_ni, .go_i(div_go), .num_i(sum_n), .den_i(vcnt_n),
    .done_o(div_done), .q_o(div_q)
  );

  // ---- sorter cell row
  cell_ctl_t ctl;
  cell_t     cw [MaxPolys];
  logic      cv [MaxPolys];
  logic      cg [MaxPolys];

  // the head cell sees a valid, never-greater neighbor on its left
  for (genvar g = 0; g < MaxPolys; g++) begin : g_cell
    rds_cell u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl),
      .left_i     (g == 0 ? cell_t'('0) : cw[(g == 0) ? 0 : g-1]),
      .left_gt_i  (g == 0 ? 1'b0 : cg[(g == 0) ? 0 : g-1]),
      .left_vld_i (g == 0 ? 1'b1 : cv[(g == 0) ? 0 : g-1]),
      .right_i    (g == MaxPolys-1 ? cell_t'('0) : cw[(g == MaxPolys-1) ? g : g+1]),
      .right_vld_i(g == MaxPolys-1 ? 1'b0 : cv[(g == MaxPolys-1) ? g : g+1]),
      .word_o(cw[g]), .vld_o(cv[g]), .gt_o(cg[g])
    );
  end

  always_comb begin
    ctl.ins   = (st_q == StIns);
    ctl.clr   = (st_q == StDrn) && (drn_q == CntW'(1));
    ctl.shift = (st_q == StDrn) && !ctl.clr;
    ctl.word.key = key_q;
    ctl.word.idx = pcnt_q[IdxW-1:0];
  end

  // ---- control
  assign busy_o = (st_q != StIdle);
  assign div_go = (st_q == StEmit) && eop_q && !dropped && avg_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (start_i) st_d = StMul;
      StMul:  st_d = StEmit;
      StEmit: begin
        if (!eop_q)        st_d = StIdle;
        else if (dropped)  st_d = eof_q ? StDrn : StIdle;
        else if (avg_q)    st_d = StDiv;
        else               st_d = StIns;
      end
      StDiv:  if (div_done) st_d = StIns;
      StIns:  st_d = eof_q ? StDrn : StIdle;
      StDrn:  if (drn_q <= CntW'(1)) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pcnt_q <= '0; sum_q <= '0; vcnt_q <= '0;
      first_q <= '0; ovf_q <= 1'b0; drn_q <= '0; didx_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StEmit) begin
        first_q <= first_n; sum_q <= sum_n; vcnt_q <= vcnt_n;
        if (eop_q && dropped) begin
          ovf_q <= 1'b1;
          sum_q <= '0; vcnt_q <= '0; first_q <= '0;
          if (eof_q) begin
            drn_q <= pcnt_q; didx_q <= '0;
          end
        end
      end
      if (st_q == StIns) begin
        pcnt_q <= pcnt_q + 1'b1;
        sum_q <= '0; vcnt_q <= '0; first_q <= '0;
        if (eof_q) begin
          drn_q <= pcnt_q + 1'b1; didx_q <= '0;
        end
      end
      if (st_q == StDrn) begin
        drn_q  <= drn_q - ((drn_q != '0) ? 1'b1 : 1'b0);
        didx_q <= didx_q + 1'b1;
        if (drn_q <= CntW'(1)) begin
          pcnt_q <= '0; ovf_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StEmit) key_q <= first_n;
    if (div_done) key_q <= div_q;
  end

  // ---- output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= (st_q == StEmit) || (st_q == StDrn && drn_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StEmit) begin
      kind_o <= 1'b0;
      x_out_o <= r0; y_out_o <= r1; z_out_o <= r2;
      polygon_index_o <= dropped ? IdxW'(31) : pcnt_q[IdxW-1:0];
      overflow_o <= dropped;
      last_o <= !eof_q;
    end else begin
      kind_o <= 1'b1;
      x_out_o <= '0; y_out_o <= '0; z_out_o <= '0;
      polygon_index_o <= (axis_q == AxisNone) ? didx_q[IdxW-1:0] : cw[0].idx;
      overflow_o <= ovf_q;
      last_o <= (drn_q == CntW'(1));
    end
  end

  property p_no_div_idle;
    @(posedge clk_i) disable iff (!rst_ni) div_go |-> st_q == StEmit;
  endproperty
  assert property (p_no_div_idle) else $error("divider started outside emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIns |=> pcnt_q == $past(pcnt_q) + 1'b1)
    else $error("polygon count not advanced on insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= CntW'(MaxPolys))
    else $error("polygon count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit |=> strobe_o && !kind_o)
    else $error("vertex word missing");
endmodule

// ===== src/rds_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_cell: one sorter cell
// Holds one (key, index) word; on insert keeps, takes the new word or takes
// the left neighbor's word. Shifts toward the head while draining.
// ----------------------------------------------------------------------------
module rds_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rds_pkg::cell_ctl_t ctl_i,
  input  rds_pkg::cell_t    left_i,
  input  logic              left_gt_i,
  input  logic              left_vld_i,
  input  rds_pkg::cell_t    right_i,
  input  logic              right_vld_i,
  output rds_pkg::cell_t    word_o,
  output logic              vld_o,
  output logic              gt_o
);
  import rds_pkg::*;

  cell_t word_q, word_d;
  logic  vld_q, vld_d;

  // strictly greater keeps ties in arrival (index) order
  assign gt_o   = vld_q && (word_q.key > ctl_i.word.key);
  assign word_o = word_q;
  assign vld_o  = vld_q;

  always_comb begin
    word_d = word_q;
    vld_d  = vld_q;
    if (ctl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctl_i.shift) begin
      word_d = right_i;
      vld_d  = right_vld_i;
    end else if (ctl_i.ins) begin
      // only the first empty cell joins the row
      if (gt_o || (!vld_q && left_vld_i)) begin
        if (left_gt_i) begin
          word_d = left_i;
        end else begin
          word_d = ctl_i.word;
        end
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end
endmodule

// ===== src/rds_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_rotate: one matrix row times the vertex
// Registered products, then rounded sum with saturation.
// ----------------------------------------------------------------------------
module rds_rotate (
  input  logic                                 clk_i,
  input  logic [3*rds_pkg::CoefW-1:0]          row_i,
  input  logic signed [rds_pkg::CoordW-1:0]    x_i,
  input  logic signed [rds_pkg::CoordW-1:0]    y_i,
  input  logic signed [rds_pkg::CoordW-1:0]    z_i,
  output logic signed [rds_pkg::OutW-1:0]      r_o
);
  import rds_pkg::*;
  localparam int PW = CoefW + CoordW;

  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic signed [PW+1:0] sum;
  logic signed [PW-15:0] sh;

  always_ff @(posedge clk_i) begin
    p0_q <= $signed(row_i[CoefW-1:0]) * x_i;
    p1_q <= $signed(row_i[2*CoefW-1:CoefW]) * y_i;
    p2_q <= $signed(row_i[3*CoefW-1:2*CoefW]) * z_i;
  end

  assign sum = (PW+2)'(p0_q) + (PW+2)'(p1_q) + (PW+2)'(p2_q) + (PW+2)'(32768);
  assign sh  = sum[PW+1:16];

  always_comb begin
    if (sh > (PW-14)'(8388607)) r_o = 24'sh7FFFFF;
    else if (sh < -(PW-14)'(8388608)) r_o = 24'sh800000;
    else r_o = sh[OutW-1:0];
  end
endmodule

// ===== src/rds_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_divider: floor division of the depth sum by the vertex count
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rds_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic signed [rds_pkg::SumW-1:0]    num_i,
  input  logic [rds_pkg::VcW-1:0]            den_i,
  output logic                               done_o,
  output logic signed [rds_pkg::OutW-1:0]    q_o
);
  import rds_pkg::*;
  localparam int CW = $clog2(SumW + 1);

  logic [SumW-1:0] quo_q, quo_d;
  logic [VcW:0]    rem_q, rem_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            neg_q, neg_d, busy_q, busy_d;
  logic [VcW-1:0]  den_q;
  logic [VcW:0]    trial;
  logic [SumW:0]   fq;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q[VcW-1:0], quo_q[SumW-1]};
    if (go_i) begin
      neg_d  = num_i[SumW-1];
      quo_d  = num_i[SumW-1] ? SumW'(-num_i) : num_i;
      rem_d  = '0;
      cnt_d  = CW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[SumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == '0);

  // floor for negatives: -(q) - (rem != 0)
  assign fq  = neg_q ? ((SumW+1)'(0) - {1'b0, quo_q} - ((rem_q != '0) ? 1'b1 : 1'b0))
                     : {1'b0, quo_q};
  assign q_o = fq[OutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; neg_q <= neg_d;
    if (go_i) den_q <= den_i;
  end
endmodule
